>>> hdl/manual_drive_esc_reverse_sequencer_defines.svh
// Assertion macros shared by the manual-drive ESC sequencer RTL.
`ifndef MANUAL_DRIVE_ESC_REVERSE_SEQUENCER_DEFINES_SVH
`define MANUAL_DRIVE_ESC_REVERSE_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define MDES_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("Same-cycle invariant violated.");
`define MDES_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("Next-cycle invariant violated.");
`else
`define MDES_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons)
`define MDES_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

>>> hdl/mdes_pkg.sv
// Shared types, constants and helpers for the manual-drive ESC sequencer.
`default_nettype none
package mdes_pkg;

  localparam int unsigned PHASE_MS = 50;
  localparam logic [7:0] REVERSE_ENTRY_POS = 8'd70;
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_SPAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_NEUTRAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_FULL_FWD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_FULL_REV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 3'd6;

  typedef struct packed {
    logic [7:0] steer_center;
    logic [6:0] steer_span;
    logic signed [7:0] trim_offset;
    logic [7:0] esc_neutral_pos;
    logic [7:0] esc_full_forward;
    logic [7:0] esc_full_reverse;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic has_command;
    logic auto_active;
    logic signed [15:0] steer_cmd;
    logic signed [15:0] throttle_cmd;
  } item_t;

  typedef struct packed {
    logic steer_write;
    logic [7:0] steer_pos;
    logic esc_write;
    logic [7:0] esc_pos;
    logic reverse_engaged;
    logic timed_out;
  } result_t;

  typedef struct packed {
    logic [7:0] steer_pos;
    logic [7:0] thr_pos;
    logic [7:0] neutral_pos;
    logic [7:0] safe_steer_pos;
  } map_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_TAP   = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_ENTER = 4'b1000
  } seq_phase_t;

  function automatic logic [7:0] sat_angle(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 11'sd0) begin
      r = 8'd0;
    end else if (v > $signed({3'b000, ANGLE_MAX})) begin
      r = ANGLE_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mdes_cfg.sv
// Configuration register file with write decode and reset values.
`default_nettype none
module mdes_cfg
  import mdes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_center <= 8'd90;
      cfg.steer_span <= 7'd30;
      cfg.trim_offset <= 8'sd0;
      cfg.esc_neutral_pos <= 8'd90;
      cfg.esc_full_forward <= 8'd180;
      cfg.esc_full_reverse <= 8'd0;
      cfg.timeout_ms <= 16'd1000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEER_CENTER: cfg.steer_center <= cfg_data[7:0];
        REG_STEER_SPAN:   cfg.steer_span <= cfg_data[6:0];
        REG_TRIM_OFFSET:  cfg.trim_offset <= $signed(cfg_data[7:0]);
        REG_ESC_NEUTRAL:  cfg.esc_neutral_pos <= cfg_data[7:0];
        REG_ESC_FULL_FWD: cfg.esc_full_forward <= cfg_data[7:0];
        REG_ESC_FULL_REV: cfg.esc_full_reverse <= cfg_data[7:0];
        REG_TIMEOUT_MS:   cfg.timeout_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/mdes_map.sv
// Steering and throttle scaling from Q1.15 stick values to servo angles.
`default_nettype none
module mdes_map
  import mdes_pkg::*;
(
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] steer_cmd,
  input  wire logic signed [15:0] throttle_cmd,
  input  wire logic               reverse_mode,
  output map_t                    mapped
);

  logic signed [23:0] steer_prod;
  logic signed [8:0]  steer_ofs;
  logic signed [10:0] center_s;
  logic signed [10:0] span_s;
  logic signed [10:0] steer_raw;
  logic signed [10:0] steer_lo;
  logic signed [10:0] steer_hi;
  logic signed [10:0] steer_clamped;
  logic signed [8:0]  neutral_s;
  logic signed [8:0]  thr_gain;
  logic signed [24:0] thr_prod;
  logic signed [9:0]  thr_ofs;
  logic signed [10:0] thr_raw;
  logic signed [10:0] safe_raw;

  assign steer_prod = steer_cmd * $signed({1'b0, cfg.steer_span});
  assign steer_ofs = steer_prod[23:15];
  assign center_s = $signed({3'b000, cfg.steer_center});
  assign span_s = $signed({4'b0000, cfg.steer_span});
  assign steer_raw = center_s + $signed({{2{steer_ofs[8]}}, steer_ofs});
  assign steer_lo = center_s - span_s;
  assign steer_hi = center_s + span_s;

  always_comb begin
    if (steer_raw < steer_lo) begin
      steer_clamped = steer_lo;
    end else if (steer_raw > steer_hi) begin
      steer_clamped = steer_hi;
    end else begin
      steer_clamped = steer_raw;
    end
  end

  assign neutral_s = $signed({1'b0, cfg.esc_neutral_pos});

  always_comb begin
    if (throttle_cmd > 16'sd0) begin
      thr_gain = $signed({1'b0, cfg.esc_full_forward}) - neutral_s;
    end else if ((throttle_cmd < 16'sd0) && reverse_mode) begin
      thr_gain = neutral_s - $signed({1'b0, cfg.esc_full_reverse});
    end else begin
      thr_gain = 9'sd0;
    end
  end

  assign thr_prod = throttle_cmd * thr_gain;
  assign thr_ofs = thr_prod[24:15];
  assign thr_raw = $signed({3'b000, cfg.esc_neutral_pos}) + $signed({thr_ofs[9], thr_ofs});
  assign safe_raw = center_s + $signed({{3{cfg.trim_offset[7]}}, cfg.trim_offset});

  assign mapped.steer_pos = sat_angle(steer_clamped);
  assign mapped.thr_pos = sat_angle(thr_raw);
  assign mapped.neutral_pos = sat_angle($signed({3'b000, cfg.esc_neutral_pos}));
  assign mapped.safe_steer_pos = sat_angle(safe_raw);

endmodule
`default_nettype wire

>>> hdl/mdes_seq.sv
// Reverse-entry sequencer, command timestamp and timeout override.
`default_nettype none
module mdes_seq
  import mdes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire item_t       item,
  input  wire map_t        mapped,
  input  wire logic [15:0] timeout_ms,
  output logic             reverse_mode,
  output result_t          result
);

  logic        seq_running;
  seq_phase_t  seq_phase;
  logic [31:0] seq_phase_start;
  logic [31:0] last_cmd_time;

  logic        reverse_mode_next;
  logic        seq_running_next;
  seq_phase_t  seq_phase_next;
  logic [31:0] seq_phase_start_next;
  logic [31:0] last_cmd_time_next;

  logic        manual_cmd;
  logic        thr_fwd;
  logic        thr_rev;
  logic        seq_start;
  logic        rm_after_thr;
  logic        run_use;
  seq_phase_t  phase_use;
  logic [31:0] start_use;
  logic [31:0] elapsed;
  logic        phase_done;
  logic [31:0] since_cmd;

  assign manual_cmd = item.has_command && !item.auto_active;
  assign thr_fwd = item.throttle_cmd > 16'sd0;
  assign thr_rev = item.throttle_cmd < 16'sd0;
  assign seq_start = manual_cmd && thr_rev && !reverse_mode && !seq_running;
  assign rm_after_thr = (manual_cmd && thr_fwd) ? 1'b0 : reverse_mode;
  assign run_use = seq_running || seq_start;
  assign phase_use = seq_start ? PH_LEAD : seq_phase;
  assign start_use = seq_start ? item.now_ms : seq_phase_start;
  assign elapsed = item.now_ms - start_use;
  assign phase_done = elapsed >= 32'(PHASE_MS);
  assign since_cmd = (item.has_command || item.auto_active) ? 32'd0 :
                     item.now_ms - last_cmd_time;

  always_comb begin
    reverse_mode_next = rm_after_thr;
    seq_running_next = run_use;
    seq_phase_next = phase_use;
    seq_phase_start_next = start_use;
    last_cmd_time_next = last_cmd_time;
    result = '0;

    if (manual_cmd) begin
      result.steer_write = 1'b1;
      result.steer_pos = mapped.steer_pos;
      result.esc_write = 1'b1;
      if (!run_use) begin
        result.esc_pos = mapped.thr_pos;
      end else begin
        unique case (phase_use)
          PH_LEAD: begin
            result.esc_pos = mapped.neutral_pos;
            if (phase_done) begin
              seq_phase_next = PH_TAP;
              seq_phase_start_next = item.now_ms;
            end
          end
          PH_TAP: begin
            result.esc_pos = 8'd0;
            if (phase_done) begin
              seq_phase_next = PH_TRAIL;
              seq_phase_start_next = item.now_ms;
            end
          end
          PH_TRAIL: begin
            result.esc_pos = mapped.neutral_pos;
            if (phase_done) begin
              seq_phase_next = PH_ENTER;
              seq_phase_start_next = item.now_ms;
            end
          end
          PH_ENTER: begin
            reverse_mode_next = 1'b1;
            seq_running_next = 1'b0;
            result.esc_pos = REVERSE_ENTRY_POS;
          end
          default: begin
            result.esc_pos = mapped.neutral_pos;
          end
        endcase
      end
      last_cmd_time_next = item.now_ms;
    end else if (item.auto_active) begin
      last_cmd_time_next = item.now_ms;
    end

    if (since_cmd > {16'd0, timeout_ms}) begin
      result.esc_write = 1'b1;
      result.esc_pos = mapped.neutral_pos;
      result.steer_write = 1'b1;
      result.steer_pos = mapped.safe_steer_pos;
      result.timed_out = 1'b1;
    end
    result.reverse_engaged = reverse_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_mode <= 1'b0;
      seq_running <= 1'b0;
      seq_phase <= PH_LEAD;
      seq_phase_start <= 32'd0;
      last_cmd_time <= 32'd0;
    end else if (advance) begin
      reverse_mode <= reverse_mode_next;
      seq_running <= seq_running_next;
      seq_phase <= seq_phase_next;
      seq_phase_start <= seq_phase_start_next;
      last_cmd_time <= last_cmd_time_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/manual_drive_esc_reverse_sequencer.sv
// A transaction is accepted into an input register and its result is written into the result
// register when it advances; a stalled output (out_valid set, out_ready low) holds it back.
// Throughput: one transaction per cycle when not stalled; the state update between consecutive
// transactions is a single combinational pass from the input register to the result register.
// Reset (synchronous, active high) empties both registers, clears the sequencer state and
// loads the configuration registers with their default values.
`default_nettype none
`include "manual_drive_esc_reverse_sequencer_defines.svh"
module manual_drive_esc_reverse_sequencer
  import mdes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           now_ms,
  input  wire logic                  has_command,
  input  wire logic                  auto_active,
  input  wire logic signed [15:0]    steer_cmd,
  input  wire logic signed [15:0]    throttle_cmd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       steer_write,
  output logic [7:0]                 steer_pos,
  output logic                       esc_write,
  output logic [7:0]                 esc_pos,
  output logic                       reverse_engaged,
  output logic                       timed_out
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_q_valid;
  logic    advance;
  logic    in_accept;
  logic    reverse_mode;
  map_t    mapped;
  result_t result;
  result_t result_q;

  assign advance = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_q.now_ms <= now_ms;
      item_q.has_command <= has_command;
      item_q.auto_active <= auto_active;
      item_q.steer_cmd <= steer_cmd;
      item_q.throttle_cmd <= throttle_cmd;
    end
  end

  mdes_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdes_map u_map (
    .cfg          (cfg),
    .steer_cmd    (item_q.steer_cmd),
    .throttle_cmd (item_q.throttle_cmd),
    .reverse_mode (reverse_mode),
    .mapped       (mapped)
  );

  mdes_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item_q),
    .mapped       (mapped),
    .timeout_ms   (cfg.timeout_ms),
    .reverse_mode (reverse_mode),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign steer_write = result_q.steer_write;
  assign steer_pos = result_q.steer_pos;
  assign esc_write = result_q.esc_write;
  assign esc_pos = result_q.esc_pos;
  assign reverse_engaged = result_q.reverse_engaged;
  assign timed_out = result_q.timed_out;

  `MDES_ASSERT_NXT(a_in_stage_loads, clk, rst, in_accept, in_q_valid)
  `MDES_ASSERT_IMP(a_timeout_writes_both, clk, rst, out_valid && timed_out,
                   steer_write && esc_write)
  `MDES_ASSERT_IMP(a_angles_in_range, clk, rst, out_valid,
                   (esc_pos <= ANGLE_MAX) && (steer_pos <= ANGLE_MAX))
  `MDES_ASSERT_IMP(a_unwritten_zero, clk, rst, out_valid && !esc_write,
                   (esc_pos == 8'd0) && !steer_write && (steer_pos == 8'd0))

endmodule
`default_nettype wire

>>> tb/manual_drive_esc_reverse_sequencer_tb.sv
// Self-checking testbench for the manual-drive steering and ESC reverse-entry sequencer.
`timescale 1ns / 1ps
module manual_drive_esc_reverse_sequencer_tb;
  import mdes_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TICKS_PER_PHASE = 105;
  localparam int PHASE_COUNT = 8;

  typedef enum int {CFG_RANDOM, CFG_LOW, CFG_HIGH, CFG_RAW} cfg_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] now_ms = '0;
  logic has_command = 1'b0;
  logic auto_active = 1'b0;
  logic signed [15:0] steer_cmd = '0;
  logic signed [15:0] throttle_cmd = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic steer_write;
  logic [7:0] steer_pos;
  logic esc_write;
  logic [7:0] esc_pos;
  logic reverse_engaged;
  logic timed_out;

  manual_drive_esc_reverse_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .now_ms(now_ms), .has_command(has_command), .auto_active(auto_active),
    .steer_cmd(steer_cmd), .throttle_cmd(throttle_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .steer_write(steer_write), .steer_pos(steer_pos),
    .esc_write(esc_write), .esc_pos(esc_pos),
    .reverse_engaged(reverse_engaged), .timed_out(timed_out)
  );

  always #10 clk = ~clk;

  cfg_t cfg = '{8'd90, 7'd30, 8'sd0, 8'd90, 8'd180, 8'd0, 16'd1000};
  logic [31:0] last_cmd_ms = '0;
  logic [31:0] phase_start_ms = '0;
  logic seq_on = 1'b0;
  logic rev_mode = 1'b0;
  seq_phase_t seq_step = PH_LEAD;

  item_t tick_q[$];
  result_t servo_q[$];
  int n_pushed = 0;
  int n_accepted = 0;
  int fault_count = 0;
  int idle_cycles = 0;
  int idle_gap_in = 0;
  int stall_out = 0;
  logic steady = 1'b0;
  logic [31:0] t_now = '0;

  function automatic logic [7:0] to_angle(input longint v);
    if (v < 0) return 8'd0;
    if (v > 180) return 8'd180;
    return v[7:0];
  endfunction

  function automatic result_t predict_servo(input item_t it);
    result_t r;
    longint c, s, sv, tv, neutral, steer, thr;
    logic [31:0] since;
    r = '0;
    neutral = longint'(cfg.esc_neutral_pos);
    if (it.has_command && !it.auto_active) begin
      c = longint'(cfg.steer_center);
      s = longint'(cfg.steer_span);
      steer = $signed(it.steer_cmd);
      thr = $signed(it.throttle_cmd);
      sv = c + ((steer * s) >>> 15);
      if (sv < c - s) sv = c - s;
      if (sv > c + s) sv = c + s;
      tv = neutral;
      if (thr > 0) begin
        rev_mode = 1'b0;
        tv = neutral + ((thr * (longint'(cfg.esc_full_forward) - neutral)) >>> 15);
      end else if (thr < 0) begin
        if (!rev_mode && !seq_on) begin
          seq_on = 1'b1;
          seq_step = PH_LEAD;
          phase_start_ms = it.now_ms;
        end else if (rev_mode) begin
          tv = neutral + ((thr * (neutral - longint'(cfg.esc_full_reverse))) >>> 15);
        end
      end
      r.steer_write = 1'b1;
      r.steer_pos = to_angle(sv);
      r.esc_write = 1'b1;
      if (!seq_on) begin
        r.esc_pos = to_angle(tv);
      end else begin
        case (seq_step)
          PH_LEAD, PH_TRAIL: begin
            r.esc_pos = to_angle(neutral);
            if (it.now_ms - phase_start_ms >= PHASE_MS) begin
              seq_step = (seq_step == PH_LEAD) ? PH_TAP : PH_ENTER;
              phase_start_ms = it.now_ms;
            end
          end
          PH_TAP: begin
            r.esc_pos = 8'd0;
            if (it.now_ms - phase_start_ms >= PHASE_MS) begin
              seq_step = PH_TRAIL;
              phase_start_ms = it.now_ms;
            end
          end
          default: begin
            rev_mode = 1'b1;
            seq_on = 1'b0;
            r.esc_pos = to_angle(longint'(REVERSE_ENTRY_POS));
          end
        endcase
      end
      last_cmd_ms = it.now_ms;
    end else if (it.auto_active) begin
      last_cmd_ms = it.now_ms;
    end
    since = it.now_ms - last_cmd_ms;
    if (since > {16'd0, cfg.timeout_ms}) begin
      r.esc_write = 1'b1;
      r.esc_pos = to_angle(neutral);
      r.steer_write = 1'b1;
      r.steer_pos = to_angle(longint'(cfg.steer_center) + longint'($signed(cfg.trim_offset)));
      r.timed_out = 1'b1;
    end
    r.reverse_engaged = rev_mode;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] any_q15();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] neg_q15();
    if ($urandom_range(0, 7) == 0) return 16'h8000;
    return 16'(-$urandom_range(1, 32767));
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 60);
    if (r < 90) return $urandom_range(61, 400);
    if (r < 97) return $urandom_range(401, 1500);
    return $urandom;
  endfunction

  task automatic note_fault(input string what, input result_t want, input result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected sw=%0d sp=%0d ew=%0d ep=%0d rev=%0d to=%0d,",
               what, want.steer_write, want.steer_pos, want.esc_write, want.esc_pos,
               want.reverse_engaged, want.timed_out);
      $display("  got sw=%0d sp=%0d ew=%0d ep=%0d rev=%0d to=%0d",
               got.steer_write, got.steer_pos, got.esc_write, got.esc_pos,
               got.reverse_engaged, got.timed_out);
    end
  endtask

  task automatic add_tick(input logic [31:0] step, input logic cmd, input logic autom,
                          input logic [15:0] st, input logic [15:0] th);
    t_now = t_now + step;
    tick_q.push_back(item_t'{t_now, cmd, autom, st, th});
    n_pushed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STEER_CENTER: cfg.steer_center = val[7:0];
      REG_STEER_SPAN: cfg.steer_span = val[6:0];
      REG_TRIM_OFFSET: cfg.trim_offset = val[7:0];
      REG_ESC_NEUTRAL: cfg.esc_neutral_pos = val[7:0];
      REG_ESC_FULL_FWD: cfg.esc_full_forward = val[7:0];
      REG_ESC_FULL_REV: cfg.esc_full_reverse = val[7:0];
      REG_TIMEOUT_MS: cfg.timeout_ms = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_pushed || servo_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_mode_t mode);
    logic [15:0] v[7];
    case (mode)
      CFG_LOW: v = '{16'd0, 16'd0, {8'd0, 8'(-90)}, 16'd0, 16'd0, 16'd0, 16'd0};
      CFG_HIGH: v = '{16'd180, 16'd90, 16'd90, 16'd180, 16'd180, 16'd180, 16'hFFFF};
      CFG_RAW: foreach (v[i]) v[i] = 16'($urandom);
      default: v = '{16'($urandom_range(0, 180)), 16'($urandom_range(0, 90)),
                     {8'd0, 8'($urandom_range(0, 180) - 90)}, 16'($urandom_range(0, 180)),
                     16'($urandom_range(0, 180)), 16'($urandom_range(0, 180)),
                     16'($urandom_range(0, 400))};
    endcase
    write_reg(REG_STEER_CENTER, v[0]);
    write_reg(REG_STEER_SPAN, v[1]);
    write_reg(REG_TRIM_OFFSET, v[2]);
    write_reg(REG_ESC_NEUTRAL, v[3]);
    write_reg(REG_ESC_FULL_FWD, v[4]);
    write_reg(REG_ESC_FULL_REV, v[5]);
    write_reg(REG_TIMEOUT_MS, v[6]);
    if (mode == CFG_RAW) write_reg(REG_UNUSED, 16'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // A reverse request followed by command ticks paced around the phase length.
  task automatic reverse_run();
    int r;
    add_tick($urandom_range(1, 30), 1'b1, 1'b0, any_q15(), neg_q15());
    repeat ($urandom_range(3, 8)) begin
      r = $urandom_range(0, 9);
      add_tick($urandom_range(0, 70), 1'b1, 1'b0, any_q15(),
               (r < 8) ? neg_q15() : (r == 8) ? 16'($urandom_range(1, 32767)) : 16'h0000);
    end
    repeat ($urandom_range(1, 4))
      add_tick($urandom_range(0, 40), 1'b1, 1'b0, any_q15(), neg_q15());
  endtask

  task automatic random_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) add_tick(pick_step(), 1'b1, 1'b0, any_q15(), any_q15());
    else if (r < 60) add_tick(pick_step(), 1'b0, 1'b0, any_q15(), any_q15());
    else if (r < 75) add_tick(pick_step(), 1'($urandom), 1'b1, any_q15(), any_q15());
    else if (r < 85) add_tick(pick_step(), 1'b1, 1'b0, any_q15(), 16'($urandom_range(1, 32767)));
    else add_tick($urandom, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    item_t x;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        servo_q.push_back(predict_servo(item_t'{now_ms, has_command, auto_active,
                                                steer_cmd, throttle_cmd}));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (idle_gap_in > 0) begin
          idle_gap_in--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          x = tick_q.pop_front();
          in_valid <= 1'b1;
          now_ms <= x.now_ms;
          has_command <= x.has_command;
          auto_active <= x.auto_active;
          steer_cmd <= x.steer_cmd;
          throttle_cmd <= x.throttle_cmd;
          idle_gap_in = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{steer_write, steer_pos, esc_write, esc_pos, reverse_engaged, timed_out};
        if (servo_q.size() == 0) begin
          note_fault("unexpected result", '0, got);
        end else begin
          want = servo_q.pop_front();
          if (got !== want) note_fault("wrong result", want, got);
        end
      end
      if (stall_out > 0) begin
        stall_out--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_out = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_mode_t plan[PHASE_COUNT];
    int target;
    plan = '{CFG_LOW, CFG_HIGH, CFG_RAW, CFG_RANDOM, CFG_RANDOM, CFG_RAW, CFG_RANDOM, CFG_RANDOM};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Full deflection, then a complete reverse-entry sequence and reverse driving.
    add_tick(32'd10, 1'b1, 1'b0, 16'h7FFF, 16'h7FFF);
    add_tick(32'd5, 1'b1, 1'b0, 16'h8000, 16'h0000);
    add_tick(32'd5, 1'b1, 1'b0, 16'h0000, 16'h8000);
    add_tick(32'd20, 1'b1, 1'b0, 16'h4000, 16'hFFFF);
    add_tick(32'd50, 1'b1, 1'b0, 16'h0000, 16'h8000);
    add_tick(32'd50, 1'b1, 1'b0, 16'h0000, 16'h8000);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0000, 16'h8000);
    add_tick(32'd1, 1'b1, 1'b0, 16'h0000, 16'h8000);
    add_tick(32'd10, 1'b1, 1'b0, 16'h8000, 16'h8000);
    add_tick(32'd10, 1'b1, 1'b0, 16'h7FFF, 16'hC000);
    add_tick(32'd10, 1'b1, 1'b0, 16'h0000, 16'h0064);
    // Forward throttle while the sequence runs does not stop it.
    add_tick(32'd10, 1'b1, 1'b0, 16'h0000, 16'hFF9C);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0000, 16'h7FFF);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0000, 16'h7FFF);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0000, 16'h0000);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0000, 16'h0000);
    // Commands under autonomous driving, then idle ticks up to and past the timeout.
    add_tick(32'd10, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
    add_tick(32'd10, 1'b0, 1'b1, 16'h0000, 16'h0000);
    add_tick(32'd500, 1'b0, 1'b0, 16'h0000, 16'h0000);
    add_tick(32'd500, 1'b0, 1'b0, 16'h0000, 16'h0000);
    add_tick(32'd1, 1'b0, 1'b0, 16'h0000, 16'h0000);
    add_tick(32'hFFFF_FFF0 - t_now, 1'b0, 1'b0, 16'h0000, 16'h0000);
    add_tick(32'd0, 1'b1, 1'b0, 16'h1234, 16'h8000);
    add_tick(32'd60, 1'b1, 1'b0, 16'hEDCB, 16'h8000);
    add_tick(32'd60, 1'b1, 1'b0, 16'h0001, 16'h8000);

    foreach (plan[p]) begin
      wait_idle();
      apply_setting(plan[p]);
      steady = ($urandom_range(0, 3) == 0);
      target = n_pushed + TICKS_PER_PHASE;
      while (n_pushed < target) begin
        if ($urandom_range(0, 1) == 0) reverse_run();
        else random_ticks();
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    fault_count += servo_q.size();
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/mdes_pkg.sv
hdl/mdes_cfg.sv
hdl/mdes_map.sv
hdl/mdes_seq.sv
hdl/manual_drive_esc_reverse_sequencer.sv
tb/manual_drive_esc_reverse_sequencer_tb.sv
